[src/ps2s2_pkg.sv]
// Shared codes, widths, result type and key table for the PS/2 set 2 decoder.
`default_nettype none
package ps2s2_pkg;

  localparam int PREFIX_COUNT_MAX = 7;
  localparam int CNT_W = $clog2(PREFIX_COUNT_MAX + 1);
  localparam int MOD_W = 9;
  localparam int CHAR_W = 7;
  localparam int BYTE_W = 8;

  localparam logic [BYTE_W-1:0] CODE_EXT    = 8'hE0;
  localparam logic [BYTE_W-1:0] CODE_BRK    = 8'hF0;
  localparam logic [BYTE_W-1:0] CODE_CTRL   = 8'h14;
  localparam logic [BYTE_W-1:0] CODE_ALT    = 8'h11;
  localparam logic [BYTE_W-1:0] CODE_CAPS   = 8'h58;
  localparam logic [BYTE_W-1:0] CODE_LSHIFT = 8'h12;
  localparam logic [BYTE_W-1:0] CODE_RSHIFT = 8'h59;
  localparam logic [BYTE_W-1:0] CODE_LGUI   = 8'h1F;
  localparam logic [BYTE_W-1:0] CODE_RGUI   = 8'h27;

  localparam int BIT_LCTRL  = 0;
  localparam int BIT_RCTRL  = 1;
  localparam int BIT_LALT   = 2;
  localparam int BIT_RALT   = 3;
  localparam int BIT_CAPS   = 4;
  localparam int BIT_LSHIFT = 5;
  localparam int BIT_RSHIFT = 6;
  localparam int BIT_LGUI   = 7;
  localparam int BIT_RGUI   = 8;

  localparam logic [CHAR_W-1:0] CHAR_NONE = 7'h00;

  typedef struct packed {
    logic              has_result;
    logic [CHAR_W-1:0] ascii_char;
    logic [MOD_W-1:0]  modifier_bits;
  } result_t;

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [BYTE_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    case (code)
      8'h1C: ch = 7'h61;
      8'h32: ch = 7'h62;
      8'h21: ch = 7'h63;
      8'h23: ch = 7'h64;
      8'h24: ch = 7'h65;
      8'h2B: ch = 7'h66;
      8'h34: ch = 7'h67;
      8'h33: ch = 7'h68;
      8'h43: ch = 7'h69;
      8'h3B: ch = 7'h6A;
      8'h42: ch = 7'h6B;
      8'h4B: ch = 7'h6C;
      8'h3A: ch = 7'h6D;
      8'h31: ch = 7'h6E;
      8'h44: ch = 7'h6F;
      8'h4D: ch = 7'h70;
      8'h15: ch = 7'h71;
      8'h2D: ch = 7'h72;
      8'h1B: ch = 7'h73;
      8'h2C: ch = 7'h74;
      8'h3C: ch = 7'h75;
      8'h2A: ch = 7'h76;
      8'h1D: ch = 7'h77;
      8'h22: ch = 7'h78;
      8'h35: ch = 7'h79;
      8'h1A: ch = 7'h7A;
      8'h45: ch = 7'h30;
      8'h16: ch = 7'h31;
      8'h1E: ch = 7'h32;
      8'h26: ch = 7'h33;
      8'h25: ch = 7'h34;
      8'h2E: ch = 7'h35;
      8'h36: ch = 7'h36;
      8'h3D: ch = 7'h37;
      8'h3E: ch = 7'h38;
      8'h46: ch = 7'h39;
      8'h0E: ch = 7'h60;
      8'h4E: ch = 7'h2D;
      8'h55: ch = 7'h3D;
      8'h5D: ch = 7'h5C;
      8'h54: ch = 7'h5B;
      8'h5B: ch = 7'h5D;
      8'h4C: ch = 7'h3B;
      8'h52: ch = 7'h27;
      8'h41: ch = 7'h2C;
      8'h49: ch = 7'h2E;
      8'h4A: ch = 7'h2F;
      8'h29: ch = 7'h20;
      8'h5A: ch = 7'h0A;
      8'h66: ch = 7'h08;
      default: ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

[src/ps2s2_in_stage.sv]
// Input register holding one received scan code word.
`default_nettype none
module ps2s2_in_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ps2s2_pkg::BYTE_W-1:0]  in_scan_byte,
  input  wire logic                          advance,
  output logic                               s1_valid,
  output logic [ps2s2_pkg::BYTE_W-1:0]       s1_byte
);

  logic                          valid_r;
  logic                          valid_nxt;
  logic [ps2s2_pkg::BYTE_W-1:0]  byte_r;
  logic                          take;

  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_scan_byte;
    end
  end

  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

endmodule
`default_nettype wire

[src/ps2s2_decode.sv]
// Prefix counters, modifier register and per-word decode logic.
`default_nettype none
module ps2s2_decode (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          s1_valid,
  input  wire logic [ps2s2_pkg::BYTE_W-1:0]  s1_byte,
  input  wire logic                          out_free,
  output logic                               advance,
  output ps2s2_pkg::result_t                 result
);

  localparam logic [ps2s2_pkg::CNT_W-1:0] CntMax =
    ps2s2_pkg::CNT_W'(ps2s2_pkg::PREFIX_COUNT_MAX);
  localparam logic [ps2s2_pkg::CNT_W-1:0] CntOne = ps2s2_pkg::CNT_W'(1);

  logic [ps2s2_pkg::CNT_W-1:0]  ext_r;
  logic [ps2s2_pkg::CNT_W-1:0]  ext_nxt;
  logic [ps2s2_pkg::CNT_W-1:0]  brk_r;
  logic [ps2s2_pkg::CNT_W-1:0]  brk_nxt;
  logic [ps2s2_pkg::MOD_W-1:0]  mod_r;
  logic [ps2s2_pkg::MOD_W-1:0]  mod_nxt;
  logic [ps2s2_pkg::CHAR_W-1:0] ch;
  logic                         ext_p;
  logic                         brk_p;
  logic                         emit;

  assign ext_p = (ext_r != '0);
  assign brk_p = (brk_r != '0);
  assign ch    = ps2s2_pkg::ascii_of(s1_byte);

  always_comb begin
    ext_nxt = ext_r;
    brk_nxt = brk_r;
    mod_nxt = mod_r;
    emit    = 1'b0;
    case (s1_byte)
      ps2s2_pkg::CODE_EXT: begin
        if (ext_r < CntMax) ext_nxt = ext_r + CntOne;
      end
      ps2s2_pkg::CODE_BRK: begin
        if (brk_r < CntMax) brk_nxt = brk_r + CntOne;
      end
      ps2s2_pkg::CODE_CTRL, ps2s2_pkg::CODE_ALT: begin
        if (ext_p && brk_p) begin
          ext_nxt = ext_r - CntOne;
          brk_nxt = brk_r - CntOne;
          if (s1_byte == ps2s2_pkg::CODE_CTRL) mod_nxt[ps2s2_pkg::BIT_RCTRL] = 1'b0;
          else mod_nxt[ps2s2_pkg::BIT_RALT] = 1'b0;
        end else if (ext_p) begin
          ext_nxt = ext_r - CntOne;
          if (s1_byte == ps2s2_pkg::CODE_CTRL) mod_nxt[ps2s2_pkg::BIT_RCTRL] = 1'b1;
          else mod_nxt[ps2s2_pkg::BIT_RALT] = 1'b1;
        end else if (brk_p) begin
          brk_nxt = brk_r - CntOne;
          if (s1_byte == ps2s2_pkg::CODE_CTRL) mod_nxt[ps2s2_pkg::BIT_LCTRL] = 1'b0;
          else mod_nxt[ps2s2_pkg::BIT_LALT] = 1'b0;
        end else begin
          if (s1_byte == ps2s2_pkg::CODE_CTRL) mod_nxt[ps2s2_pkg::BIT_LCTRL] = 1'b1;
          else mod_nxt[ps2s2_pkg::BIT_LALT] = 1'b1;
        end
      end
      ps2s2_pkg::CODE_CAPS: begin
        if (brk_p) brk_nxt = brk_r - CntOne;
        mod_nxt[ps2s2_pkg::BIT_CAPS] = !brk_p;
      end
      ps2s2_pkg::CODE_LSHIFT: begin
        if (brk_p) brk_nxt = brk_r - CntOne;
        mod_nxt[ps2s2_pkg::BIT_LSHIFT] = !brk_p;
      end
      ps2s2_pkg::CODE_RSHIFT: begin
        if (brk_p) brk_nxt = brk_r - CntOne;
        mod_nxt[ps2s2_pkg::BIT_RSHIFT] = !brk_p;
      end
      ps2s2_pkg::CODE_LGUI, ps2s2_pkg::CODE_RGUI: begin
        if (ext_p) begin
          ext_nxt = ext_r - CntOne;
          if (brk_p) brk_nxt = brk_r - CntOne;
          if (s1_byte == ps2s2_pkg::CODE_LGUI) mod_nxt[ps2s2_pkg::BIT_LGUI] = !brk_p;
          else mod_nxt[ps2s2_pkg::BIT_RGUI] = !brk_p;
        end
      end
      default: begin
        if (ch != ps2s2_pkg::CHAR_NONE) begin
          if (brk_p) brk_nxt = brk_r - CntOne;
          else emit = 1'b1;
        end
      end
    endcase
  end

  assign advance              = s1_valid && (out_free || !emit);
  assign result.has_result    = emit;
  assign result.ascii_char    = ch;
  assign result.modifier_bits = mod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_r <= '0;
      brk_r <= '0;
      mod_r <= '0;
    end else if (advance) begin
      ext_r <= ext_nxt;
      brk_r <= brk_nxt;
      mod_r <= mod_nxt;
    end
  end

endmodule
`default_nettype wire

[src/ps2s2_out_stage.sv]
// Result register presenting one decoded key word to the receiver.
`default_nettype none
module ps2s2_out_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          advance,
  input  wire ps2s2_pkg::result_t            result,
  output logic                               out_free,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ps2s2_pkg::CHAR_W-1:0]       out_ascii_char,
  output logic [ps2s2_pkg::MOD_W-1:0]        out_modifier_bits
);

  logic                          valid_r;
  logic                          valid_nxt;
  logic [ps2s2_pkg::CHAR_W-1:0]  char_r;
  logic [ps2s2_pkg::MOD_W-1:0]   mod_r;
  logic                          load;

  assign out_free = !valid_r || !out_stall;
  assign load     = advance && result.has_result;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= result.ascii_char;
      mod_r  <= result.modifier_bits;
    end
  end

  assign out_valid         = valid_r;
  assign out_ascii_char    = char_r;
  assign out_modifier_bits = mod_r;

endmodule
`default_nettype wire

[src/ps2_set2_scancode_decoder.sv]
// Top level of the PS/2 scan code set 2 decoder with modifier tracking.
// Input channel: in_valid / in_stall carry one scan code word (in_scan_byte)
//   per accepted cycle; a word is taken at a clock edge with in_valid high
//   and in_stall low.
// Result channel: out_valid / out_stall carry the ASCII code of a pressed
//   printable key and a snapshot of the nine modifier bits held at that time.
//   Prefix, modifier, break and unknown words give no result.
// Path: the input register takes the word at its accepting edge and the
//   result register loads at the edge on which the word leaves the input
//   register, so out_valid rises once the word has passed both registers.
// Throughput: one word per cycle while in_stall is low; the prefix counters
//   and modifier register update in the same cycle the word leaves the input register.
// Stall: while out_stall holds a waiting result, words that give no result
//   still pass; a word that gives a result waits in the input register and
//   in_stall rises until the result register frees.
// Reset: rst_n low at a clock edge clears both prefix counts, the modifier
//   register and both valid flags.
`default_nettype none
module ps2_set2_scancode_decoder (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ps2s2_pkg::BYTE_W-1:0]  in_scan_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ps2s2_pkg::CHAR_W-1:0]       out_ascii_char,
  output logic [ps2s2_pkg::MOD_W-1:0]        out_modifier_bits
);

  logic                          s1_valid;
  logic [ps2s2_pkg::BYTE_W-1:0]  s1_byte;
  logic                          advance;
  logic                          out_free;
  ps2s2_pkg::result_t            result;

  ps2s2_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_scan_byte (in_scan_byte),
    .advance      (advance),
    .s1_valid     (s1_valid),
    .s1_byte      (s1_byte)
  );

  ps2s2_decode u_dec (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte),
    .out_free (out_free),
    .advance  (advance),
    .result   (result)
  );

  ps2s2_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .advance           (advance),
    .result            (result),
    .out_free          (out_free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ascii_char    (out_ascii_char),
    .out_modifier_bits (out_modifier_bits)
  );

endmodule
`default_nettype wire

[src/ps2s2_checker.sv]
// Port-level checks for the PS/2 set 2 decoder and their bind.
`default_nettype none
module ps2s2_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic [ps2s2_pkg::BYTE_W-1:0]  in_scan_byte,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [ps2s2_pkg::CHAR_W-1:0]  out_ascii_char,
  input wire logic [ps2s2_pkg::MOD_W-1:0]   out_modifier_bits
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_ascii_char != ps2s2_pkg::CHAR_NONE)
    else $error("result word with empty character");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side free");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ascii_char)
      && $stable(out_modifier_bits))
    else $error("stalled result word changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_scan_byte))
    else $error("stalled input word changed");

endmodule

bind ps2_set2_scancode_decoder ps2s2_checker u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_scan_byte      (in_scan_byte),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_ascii_char    (out_ascii_char),
  .out_modifier_bits (out_modifier_bits)
);
`default_nettype wire
